FILE: src/crt_pkg.sv
// Package for the countdown relay timer: phase codes, register indexes,
// state, configuration and result types. No dependencies.
`default_nettype none

package crt_pkg;

  localparam int unsigned SecW   = 10;
  localparam int unsigned MsW    = 16;
  localparam int unsigned DigitW = 4;
  localparam int unsigned ChirpW = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PRE   = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;
  localparam logic [1:0] PH_CHIRP = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_MAX_SECONDS   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_MS   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESTART_CNT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_SEC = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_AMBER_FLASH   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CHIRP_ON      = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_CHIRP_OFF     = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_CHIRP_CNT     = 3'd7;

  typedef struct packed {
    logic [SecW-1:0]   max_seconds;
    logic [MsW-1:0]    debounce_ms;
    logic [DigitW-1:0] prestart_count;
    logic [MsW-1:0]    ticks_per_second;
    logic [MsW-1:0]    amber_flash_ms;
    logic [MsW-1:0]    chirp_on_ms;
    logic [MsW-1:0]    chirp_off_ms;
    logic [ChirpW-1:0] chirp_count;
  } crt_cfg_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [SecW-1:0]   seconds;
    logic [SecW-1:0]   saved;
    logic              run;
    logic              prev_a;
    logic              prev_btn;
    logic [MsW-1:0]    since;
    logic [MsW-1:0]    ms;
    logic [DigitW-1:0] pre_left;
    logic [ChirpW-1:0] chirp_idx;
    logic              gap;
  } crt_state_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [DigitW-1:0] prestart_digit;
    logic [SecW-1:0]   shown_seconds;
    logic              buzzer;
    logic              chirp_lamp;
    logic              run_lamp;
    logic              relay_on;
  } crt_result_t;

endpackage

`default_nettype wire

FILE: src/countdown_relay_timer.sv
// Top level of the countdown relay timer: stream ports, config registers,
// input and result registers around crt_step. Depends on crt_pkg, crt_step.
//
// channel  | direction | payload
// s_axis   | in        | tdata: enc_a, enc_b, button (bits 2:0), one tick per transaction
// m_axis   | out       | tdata: relay_on, run_lamp, chirp_lamp, buzzer, shown_seconds,
//          |           |        prestart_digit, phase (bits 19:0)
// cfg      | in        | write enable, 3-bit register index, 16-bit data
//
// One tick per cycle while the result side is not stalled: input register, one pass of
// next-state logic, result register.
// Reset restores power-on register values and idle state (encoder/button seen high).
// A stalled result holds; the input register still drains into it once it is taken.
`default_nettype none

module countdown_relay_timer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [crt_pkg::InDataW-1:0]       s_axis_tdata,   // enc_a, enc_b, button, pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // relay_on, run_lamp, chirp_lamp, buzzer, shown_seconds[9:0], prestart_digit[3:0],
  // phase[1:0], pad
  output logic [crt_pkg::OutDataW-1:0]      m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [crt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [crt_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  crt_pkg::crt_cfg_t    cfg_q;
  crt_pkg::crt_state_t  state_q, state_d;
  crt_pkg::crt_result_t result_d;

  logic       in_valid_q;
  logic [2:0] in_data_q;
  logic       out_valid_q;
  logic [crt_pkg::OutDataW-1:0] out_data_q;
  logic       advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_seconds      <= 10'd300;
      cfg_q.debounce_ms      <= 16'd250;
      cfg_q.prestart_count   <= 4'd5;
      cfg_q.ticks_per_second <= 16'd1000;
      cfg_q.amber_flash_ms   <= 16'd150;
      cfg_q.chirp_on_ms      <= 16'd150;
      cfg_q.chirp_off_ms     <= 16'd100;
      cfg_q.chirp_count      <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crt_pkg::CFG_MAX_SECONDS:   cfg_q.max_seconds      <= cfg_wdata_i[9:0];
        crt_pkg::CFG_DEBOUNCE_MS:   cfg_q.debounce_ms      <= cfg_wdata_i;
        crt_pkg::CFG_PRESTART_CNT:  cfg_q.prestart_count   <= cfg_wdata_i[3:0];
        crt_pkg::CFG_TICKS_PER_SEC: cfg_q.ticks_per_second <= cfg_wdata_i;
        crt_pkg::CFG_AMBER_FLASH:   cfg_q.amber_flash_ms   <= cfg_wdata_i;
        crt_pkg::CFG_CHIRP_ON:      cfg_q.chirp_on_ms      <= cfg_wdata_i;
        crt_pkg::CFG_CHIRP_OFF:     cfg_q.chirp_off_ms     <= cfg_wdata_i;
        crt_pkg::CFG_CHIRP_CNT:     cfg_q.chirp_count      <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  crt_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .enc_a_i  (in_data_q[0]),
    .enc_b_i  (in_data_q[1]),
    .button_i (in_data_q[2]),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= crt_pkg::PH_IDLE;
      state_q.seconds   <= '0;
      state_q.saved     <= '0;
      state_q.run       <= 1'b0;
      state_q.prev_a    <= 1'b1;
      state_q.prev_btn  <= 1'b1;
      state_q.since     <= '0;
      state_q.ms        <= '0;
      state_q.pre_left  <= '0;
      state_q.chirp_idx <= '0;
      state_q.gap       <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata[2:0];
    end
    if (advance) begin
      out_data_q <= {4'd0, result_d};
    end
  end

  // idle leaves no run bookkeeping behind
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == crt_pkg::PH_IDLE) |->
      (state_q.pre_left == '0 && !state_q.gap && state_q.ms == '0 &&
       state_q.chirp_idx == '0))
    else $error("idle phase with stale run state");

  // prestart always has a count left to show
  a_pre_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == crt_pkg::PH_PRE) |-> (state_q.pre_left != '0))
    else $error("prestart phase with zero count");

  // a processed tick always lands in the result register
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed tick lost");

  // the gap flag only exists inside chirps
  a_gap_chirp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.gap |-> (state_q.phase == crt_pkg::PH_CHIRP))
    else $error("chirp gap outside chirp phase");

endmodule

`default_nettype wire

FILE: src/crt_step.sv
// One-tick next-state and result logic of the countdown relay timer.
// Depends on crt_pkg.
`default_nettype none

module crt_step (
  input  crt_pkg::crt_cfg_t    cfg_i,
  input  crt_pkg::crt_state_t  state_i,
  input  logic                 enc_a_i,
  input  logic                 enc_b_i,
  input  logic                 button_i,
  output crt_pkg::crt_state_t  state_o,
  output crt_pkg::crt_result_t result_o
);

  function automatic crt_pkg::crt_state_t end_run(crt_pkg::crt_state_t s);
    crt_pkg::crt_state_t r;
    r           = s;
    r.seconds   = s.saved;
    r.run       = 1'b0;
    r.phase     = crt_pkg::PH_IDLE;
    r.ms        = '0;
    r.pre_left  = '0;
    r.chirp_idx = '0;
    r.gap       = 1'b0;
    return r;
  endfunction

  function automatic crt_pkg::crt_state_t begin_chirps(crt_pkg::crt_state_t s,
                                                       logic [crt_pkg::ChirpW-1:0] cnt);
    crt_pkg::crt_state_t r;
    r = s;
    if (cnt == '0) begin
      r = end_run(s);
    end else begin
      r.phase     = crt_pkg::PH_CHIRP;
      r.ms        = '0;
      r.chirp_idx = '0;
      r.gap       = 1'b0;
    end
    return r;
  endfunction

  function automatic crt_pkg::crt_state_t begin_countdown(crt_pkg::crt_state_t s,
                                                          logic [crt_pkg::ChirpW-1:0] cnt);
    crt_pkg::crt_state_t r;
    r          = s;
    r.pre_left = '0;
    r.ms       = '0;
    if (r.seconds == '0) begin
      r = begin_chirps(r, cnt);
    end else begin
      r.phase = crt_pkg::PH_RUN;
    end
    return r;
  endfunction

  crt_pkg::crt_state_t s;
  logic [crt_pkg::MsW-1:0] part_len;
  logic [crt_pkg::MsW-1:0] ms_inc;
  logic                    part_done;
  logic [crt_pkg::ChirpW-1:0] ci_inc;

  // shared part timer: chirp on/off lengths in the chirp phase, the seconds length otherwise
  always_comb begin
    if (state_i.phase == crt_pkg::PH_CHIRP) begin
      part_len = state_i.gap ? cfg_i.chirp_off_ms : cfg_i.chirp_on_ms;
    end else begin
      part_len = cfg_i.ticks_per_second;
    end
    ms_inc    = state_i.ms + 16'd1;
    part_done = (ms_inc >= part_len) || (ms_inc == '0);
    ci_inc    = state_i.chirp_idx + 3'd1;
  end

  always_comb begin
    s = state_i;

    if (s.since != '1) begin
      s.since = s.since + 16'd1;
    end
    if (s.prev_btn && !button_i) begin
      if (s.since > cfg_i.debounce_ms) begin
        s.run = ~s.run;
      end
      s.since = '0;
    end
    s.prev_btn = button_i;

    unique case (s.phase)
      crt_pkg::PH_IDLE: begin
        if (s.run) begin
          s.saved     = s.seconds;
          s.ms        = '0;
          s.chirp_idx = '0;
          s.gap       = 1'b0;
          s.pre_left  = cfg_i.prestart_count;
          if (cfg_i.prestart_count == '0) begin
            s = begin_countdown(s, cfg_i.chirp_count);
          end else begin
            s.phase = crt_pkg::PH_PRE;
          end
        end else begin
          if (s.prev_a && !enc_a_i) begin
            if (enc_b_i) begin
              if (s.seconds < cfg_i.max_seconds) begin
                s.seconds = s.seconds + 10'd1;
              end
            end else if (s.seconds != '0) begin
              s.seconds = s.seconds - 10'd1;
            end
          end
          s.prev_a = enc_a_i;
        end
      end
      crt_pkg::PH_PRE: begin
        if (!s.run) begin
          s = end_run(s);
        end else begin
          s.ms = ms_inc;
          if (part_done) begin
            s.ms = '0;
            if (s.pre_left <= 4'd1) begin
              s = begin_countdown(s, cfg_i.chirp_count);
            end else begin
              s.pre_left = s.pre_left - 4'd1;
            end
          end
        end
      end
      crt_pkg::PH_RUN: begin
        if (!s.run) begin
          s = end_run(s);
        end else begin
          s.ms = ms_inc;
          if (part_done) begin
            s.ms = '0;
            if (s.seconds <= 10'd1) begin
              s.seconds = '0;
              s = begin_chirps(s, cfg_i.chirp_count);
            end else begin
              s.seconds = s.seconds - 10'd1;
            end
          end
        end
      end
      crt_pkg::PH_CHIRP: begin
        s.ms = ms_inc;
        if (part_done) begin
          s.ms = '0;
          if (!s.gap) begin
            s.gap = 1'b1;
          end else begin
            s.gap       = 1'b0;
            s.chirp_idx = ci_inc;
            if ((ci_inc >= cfg_i.chirp_count) || (ci_inc == '0)) begin
              s = end_run(s);
            end
          end
        end
      end
      default: begin
        s = state_i;
      end
    endcase
  end

  assign state_o = s;

  always_comb begin
    result_o.relay_on       = (s.phase == crt_pkg::PH_RUN);
    result_o.run_lamp       = (s.phase == crt_pkg::PH_RUN) ||
                              ((s.phase == crt_pkg::PH_PRE) && (s.ms < cfg_i.amber_flash_ms));
    result_o.chirp_lamp     = (s.phase == crt_pkg::PH_CHIRP) && !s.gap;
    result_o.buzzer         = (s.phase == crt_pkg::PH_CHIRP) && !s.gap;
    result_o.shown_seconds  = s.seconds;
    result_o.prestart_digit = (s.phase == crt_pkg::PH_PRE) ? s.pre_left : '0;
    result_o.phase          = s.phase;
  end

endmodule

`default_nettype wire

FILE: verif/timer_checker.sv
// Checker for the countdown relay timer: keeps its own copy of the timer state,
// predicts one output word per input tick and compares it with the m_axis stream.
// Depends on crt_pkg.

module timer_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [crt_pkg::InDataW-1:0]  s_axis_tdata,   // enc_a, enc_b, button, pad
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // relay_on, run_lamp, chirp_lamp, buzzer, shown_seconds[9:0], prestart_digit[3:0],
  // phase[1:0], pad
  input  logic [crt_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [crt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [crt_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  ticks_o,
  output int unsigned                  runs_o,
  output int unsigned                  finished_o,
  output int unsigned                  aborted_o
);

  // timer state
  logic [1:0]  ph;
  logic [9:0]  secs, saved;
  logic        run, last_a, last_btn, in_gap;
  logic [15:0] since_press, ms_cnt;
  logic [3:0]  pre_left;
  logic [2:0]  chirp_idx;

  // register copies
  logic [9:0]  max_secs;
  logic [15:0] debounce, sec_len, amber_len, chirp_on_len, chirp_off_len;
  logic [3:0]  pre_count;
  logic [2:0]  chirps;

  crt_pkg::crt_result_t expected_outputs [$];
  crt_pkg::crt_result_t want, got;

  function automatic void finish_run();
    secs      = saved;
    run       = 1'b0;
    ph        = crt_pkg::PH_IDLE;
    ms_cnt    = '0;
    pre_left  = '0;
    chirp_idx = '0;
    in_gap    = 1'b0;
  endfunction

  function automatic void start_chirps();
    finished_o++;
    if (chirps == 0) begin
      finish_run();
    end else begin
      ph        = crt_pkg::PH_CHIRP;
      ms_cnt    = '0;
      chirp_idx = '0;
      in_gap    = 1'b0;
    end
  endfunction

  function automatic void start_countdown();
    pre_left = '0;
    ms_cnt   = '0;
    if (secs == 0) start_chirps();
    else ph = crt_pkg::PH_RUN;
  endfunction

  // one more tick in the current part; zero length counts as one tick
  function automatic logic part_elapsed(logic [15:0] len);
    ms_cnt = ms_cnt + 16'd1;
    return (ms_cnt >= len) || (ms_cnt == 16'd0);
  endfunction

  function automatic crt_pkg::crt_result_t advance_tick(logic a, logic b, logic btn);
    crt_pkg::crt_result_t r;
    if (since_press != 16'hFFFF) since_press++;
    if (last_btn && !btn) begin
      if (since_press > debounce) run = ~run;
      since_press = '0;
    end
    last_btn = btn;

    case (ph)
      crt_pkg::PH_IDLE: begin
        if (run) begin
          runs_o++;
          saved     = secs;
          ms_cnt    = '0;
          chirp_idx = '0;
          in_gap    = 1'b0;
          pre_left  = pre_count;
          if (pre_left == 0) start_countdown();
          else ph = crt_pkg::PH_PRE;
        end else begin
          if (last_a && !a) begin
            if (b != a) begin
              if (secs < max_secs) secs++;
            end else if (secs != 0) begin
              secs--;
            end
          end
          last_a = a;
        end
      end
      crt_pkg::PH_PRE: begin
        if (!run) begin
          aborted_o++;
          finish_run();
        end else if (part_elapsed(sec_len)) begin
          ms_cnt = '0;
          if (pre_left <= 1) start_countdown();
          else pre_left--;
        end
      end
      crt_pkg::PH_RUN: begin
        if (!run) begin
          aborted_o++;
          finish_run();
        end else if (part_elapsed(sec_len)) begin
          ms_cnt = '0;
          if (secs <= 1) begin
            secs = '0;
            start_chirps();
          end else begin
            secs--;
          end
        end
      end
      default: begin
        // chirps finish regardless of presses
        if (!in_gap) begin
          if (part_elapsed(chirp_on_len)) begin
            ms_cnt = '0;
            in_gap = 1'b1;
          end
        end else if (part_elapsed(chirp_off_len)) begin
          ms_cnt    = '0;
          in_gap    = 1'b0;
          chirp_idx = chirp_idx + 3'd1;
          if (chirp_idx >= chirps || chirp_idx == 0) finish_run();
        end
      end
    endcase

    r.phase          = ph;
    r.relay_on       = (ph == crt_pkg::PH_RUN);
    r.run_lamp       = (ph == crt_pkg::PH_RUN) ||
                       (ph == crt_pkg::PH_PRE && ms_cnt < amber_len);
    r.chirp_lamp     = (ph == crt_pkg::PH_CHIRP) && !in_gap;
    r.buzzer         = (ph == crt_pkg::PH_CHIRP) && !in_gap;
    r.shown_seconds  = secs;
    r.prestart_digit = (ph == crt_pkg::PH_PRE) ? pre_left : '0;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_outputs.delete();
      ph            = crt_pkg::PH_IDLE;
      secs          = '0;
      saved         = '0;
      run           = 1'b0;
      last_a        = 1'b1;
      last_btn      = 1'b1;
      since_press   = '0;
      ms_cnt        = '0;
      pre_left      = '0;
      chirp_idx     = '0;
      in_gap        = 1'b0;
      max_secs      = 10'd300;
      debounce      = 16'd250;
      pre_count     = 4'd5;
      sec_len       = 16'd1000;
      amber_len     = 16'd150;
      chirp_on_len  = 16'd150;
      chirp_off_len = 16'd100;
      chirps        = 3'd3;
      fail_count_o  = 0;
      pending_o     = 0;
      ticks_o       = 0;
      runs_o        = 0;
      finished_o    = 0;
      aborted_o     = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(crt_pkg::crt_result_t)-1:0];
        if (expected_outputs.size() == 0) begin
          $error("output transaction with no tick outstanding");
          fail_count_o++;
        end else begin
          want = expected_outputs.pop_front();
          check_field("relay_on", want.relay_on, got.relay_on);
          check_field("run_lamp", want.run_lamp, got.run_lamp);
          check_field("chirp_lamp", want.chirp_lamp, got.chirp_lamp);
          check_field("buzzer", want.buzzer, got.buzzer);
          check_field("shown_seconds", want.shown_seconds, got.shown_seconds);
          check_field("prestart_digit", want.prestart_digit, got.prestart_digit);
          check_field("phase", want.phase, got.phase);
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          crt_pkg::CFG_MAX_SECONDS:   max_secs      = cfg_wdata_i[crt_pkg::SecW-1:0];
          crt_pkg::CFG_DEBOUNCE_MS:   debounce      = cfg_wdata_i;
          crt_pkg::CFG_PRESTART_CNT:  pre_count     = cfg_wdata_i[crt_pkg::DigitW-1:0];
          crt_pkg::CFG_TICKS_PER_SEC: sec_len       = cfg_wdata_i;
          crt_pkg::CFG_AMBER_FLASH:   amber_len     = cfg_wdata_i;
          crt_pkg::CFG_CHIRP_ON:      chirp_on_len  = cfg_wdata_i;
          crt_pkg::CFG_CHIRP_OFF:     chirp_off_len = cfg_wdata_i;
          crt_pkg::CFG_CHIRP_CNT:     chirps        = cfg_wdata_i[crt_pkg::ChirpW-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        expected_outputs.push_back(advance_tick(s_axis_tdata[0], s_axis_tdata[1],
                                                s_axis_tdata[2]));
        ticks_o++;
      end
      pending_o = expected_outputs.size();
    end
  end

endmodule

FILE: verif/countdown_relay_timer_test.sv
// Testbench top for the countdown relay timer: drives encoder/button ticks and
// register writes, stalls the output side, and reports the verdict.
// Depends on crt_pkg, countdown_relay_timer and timer_checker.

module countdown_relay_timer_test;

  localparam int NumRegs = 1 << crt_pkg::CfgIdxW;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // enc_a, enc_b, button, pad
  logic [crt_pkg::InDataW-1:0]  s_axis_tdata = crt_pkg::InDataW'(3'b111);
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // relay_on, run_lamp, chirp_lamp, buzzer, shown_seconds[9:0], prestart_digit[3:0],
  // phase[1:0], pad
  logic [crt_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         cfg_we = 1'b0;
  logic [crt_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [crt_pkg::CfgDataW-1:0] cfg_wdata = '0;

  int unsigned fail_count, pending, ticks, runs, finished, aborted;
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  int unsigned quiet_left = 0;
  bit          stall_done = 1'b0;
  logic [crt_pkg::CfgDataW-1:0] next_regs [NumRegs];

  countdown_relay_timer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  timer_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .ticks_o       (ticks),
    .runs_o        (runs),
    .finished_o    (finished),
    .aborted_o     (aborted)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL");
    $finish;
  end

  // one tick transaction; called and returns at a falling edge
  task automatic send_tick(input logic a, input logic b, input logic btn);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
      gap = 0;
    end else if (roll < 3) begin
      quiet_left = $urandom_range(20, 80);
      gap = 0;
    end else if (roll < 60) begin
      gap = 0;
    end else if (roll < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(4, 25);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(crt_pkg::InDataW-3){1'b0}}, btn, b, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic turn_encoder(input int steps, input bit up);
    repeat (steps) begin
      send_tick(1'b1, 1'($urandom), 1'b1);
      send_tick(1'b0, up, 1'b1);
    end
  endtask

  task automatic press_button(input int hold);
    repeat (hold) send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  // let every outstanding tick come out before touching registers
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_registers();
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= crt_pkg::CfgIdxW'(i);
      cfg_wdata <= next_regs[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic configure(input int max_s, input int deb, input int pre, input int sec,
                           input int amber, input int c_on, input int c_off,
                           input int c_cnt);
    next_regs[crt_pkg::CFG_MAX_SECONDS]   = crt_pkg::CfgDataW'(max_s);
    next_regs[crt_pkg::CFG_DEBOUNCE_MS]   = crt_pkg::CfgDataW'(deb);
    next_regs[crt_pkg::CFG_PRESTART_CNT]  = crt_pkg::CfgDataW'(pre);
    next_regs[crt_pkg::CFG_TICKS_PER_SEC] = crt_pkg::CfgDataW'(sec);
    next_regs[crt_pkg::CFG_AMBER_FLASH]   = crt_pkg::CfgDataW'(amber);
    next_regs[crt_pkg::CFG_CHIRP_ON]      = crt_pkg::CfgDataW'(c_on);
    next_regs[crt_pkg::CFG_CHIRP_OFF]     = crt_pkg::CfgDataW'(c_off);
    next_regs[crt_pkg::CFG_CHIRP_CNT]     = crt_pkg::CfgDataW'(c_cnt);
    write_registers();
  endtask

  // short timings so runs complete within a few hundred ticks
  task automatic configure_random();
    int sec;
    sec = $urandom_range(0, 5);
    configure(($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, 15),
              $urandom_range(0, 6), $urandom_range(0, 4), sec,
              $urandom_range(0, sec + 1), $urandom_range(0, 4),
              $urandom_range(0, 4), $urandom_range(0, 7));
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    int roll;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        turn_encoder($urandom_range(1, 6), $urandom_range(0, 9) < 7);
      end else if (roll < 48) begin
        press_button($urandom_range(1, 3));
      end else if (roll < 85) begin
        repeat ($urandom_range(1, 60)) send_tick(1'b1, 1'b1, 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  // output side: random bursts and gaps, one long hold-off to back up the input
  initial begin : sink
    int burst;
    int span;
    @(posedge rst_n);
    forever begin
      if (!stall_done && items_sent >= 100) begin
        m_axis_tready <= 1'b0;
        repeat (150) @(negedge clk);
        stall_done = 1'b1;
      end
      m_axis_tready <= 1'b1;
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
      repeat (burst) @(negedge clk);
      span = $urandom_range(0, 99);
      if (span < 70) span = 0;
      else if (span < 90) span = $urandom_range(1, 3);
      else span = $urandom_range(4, 30);
      if (span > 0) begin
        m_axis_tready <= 1'b0;
        repeat (span) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // power-on registers: decrement at zero, two increments, early press ignored
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);

    // ceiling below preset, no prestart, zero-length seconds and chirps
    drain();
    configure(1, 0, 0, 0, 65535, 0, 0, 1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    // start, then abort mid-countdown
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);

    // zero ceiling, zero preset at countdown entry, no chirps, no amber flash
    drain();
    configure(0, 0, 1, 1, 0, 65535, 65535, 0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);

    drain();
    configure(1023, 0, 15, 1, 65535, 1, 1, 7);
    random_traffic(300);
    // presses never pass the debounce window
    drain();
    configure(1, 65535, 0, 65535, 0, 65535, 65535, 0);
    random_traffic(60);
    // very long seconds; a run started here is cut short by the next settings
    drain();
    configure(300, 3, 2, 65535, 65535, 3, 3, 2);
    random_traffic(80);
    repeat (5) begin
      drain();
      configure_random();
      random_traffic(310);
    end

    drain();
    $display("%0d ticks checked under %0d register settings, %0d output errors.",
             ticks, settings_used, fail_count);
    $display("%0d runs started, %0d counted down to zero, %0d aborted.",
             runs, finished, aborted);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
